// ===== src/quaternion_arithmetic_unit_assert.svh =====
// Assertion macros for the quaternion arithmetic unit.
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("qau assertion failed");
`define QAU_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("qau assertion failed");
`else
`define QAU_ASSERT(label, clk, rst_n, prop)
`define QAU_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== src/qau_pkg.sv =====
package qau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_SUB      = 3'd1,
        CMD_MUL      = 3'd2,
        CMD_SCALE    = 3'd3,
        CMD_CONJ     = 3'd4,
        CMD_ROT      = 3'd5,
        CMD_ROT_CONJ = 3'd6,
        CMD_NORM     = 3'd7
    } t_cmd;

endpackage

// ===== src/qau_in_if.sv =====
interface qau_in_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    qau_pkg::t_cmd                     command;
    logic signed [COMPONENT_WIDTH-1:0] a_w;
    logic signed [COMPONENT_WIDTH-1:0] a_x;
    logic signed [COMPONENT_WIDTH-1:0] a_y;
    logic signed [COMPONENT_WIDTH-1:0] a_z;
    logic signed [COMPONENT_WIDTH-1:0] b_w;
    logic signed [COMPONENT_WIDTH-1:0] b_x;
    logic signed [COMPONENT_WIDTH-1:0] b_y;
    logic signed [COMPONENT_WIDTH-1:0] b_z;
    logic signed [COMPONENT_WIDTH-1:0] scalar;

    modport source (
        output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
        input  ready
    );
    modport sink (
        input  valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
        output ready
    );
endinterface

// ===== src/qau_out_if.sv =====
interface qau_out_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] r_w;
    logic signed [COMPONENT_WIDTH-1:0] r_x;
    logic signed [COMPONENT_WIDTH-1:0] r_y;
    logic signed [COMPONENT_WIDTH-1:0] r_z;
    logic                              saturated;

    modport source (
        output valid, r_w, r_x, r_y, r_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, r_w, r_x, r_y, r_z, saturated,
        output ready
    );
endinterface

// ===== src/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit, six register stages.
// Every command passes through every stage from input accept to output valid.
// Throughput: one item per cycle; a stalled output holds each stage in place,
// and empty stages close up so a new item is taken while a result waits.
// Reset (synchronous, active low) clears the stage valid bits; data is not reset.
`include "quaternion_arithmetic_unit_assert.svh"

module quaternion_arithmetic_unit #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qau_in_if.sink    i_in,
    qau_out_if.source o_out
);
    localparam int W  = COMPONENT_WIDTH;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 3;
    localparam int LW = W + 2;

    typedef logic signed [W-1:0]  t_comp;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [SW-1:0] t_sum;
    typedef logic signed [LW-1:0] t_lin;

    localparam t_sum  HALF = t_sum'(1) <<< (FRACTION_BITS - 1);
    localparam t_sum  SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam t_sum  SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam t_comp CMAX = {1'b0, {(W-1){1'b1}}};
    localparam t_comp CMIN = {1'b1, {(W-1){1'b0}}};

    function automatic t_sum ext(input t_prod p);
        ext = t_sum'(p);
    endfunction

    function automatic t_sum rnd(input t_sum v);
        rnd = (v + HALF) >>> FRACTION_BITS;
    endfunction

    function automatic logic is_clip(input t_sum v);
        is_clip = (v > SMAX) || (v < SMIN);
    endfunction

    function automatic t_comp sat(input t_sum v);
        if (v > SMAX) begin
            sat = CMAX;
        end else if (v < SMIN) begin
            sat = CMIN;
        end else begin
            sat = t_comp'(v[W-1:0]);
        end
    endfunction

    // stage enables
    logic s1_en, s2_en, s3_en, s4_en, s5_en, s6_en;
    logic r_vld1, r_vld2, r_vld3, r_vld4, r_vld5, r_out_vld;

    assign s6_en = !r_out_vld || o_out.ready;
    assign s5_en = !r_vld5 || s6_en;
    assign s4_en = !r_vld4 || s5_en;
    assign s3_en = !r_vld3 || s4_en;
    assign s2_en = !r_vld2 || s3_en;
    assign s1_en = !r_vld1 || s2_en;
    assign i_in.ready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_vld4    <= 1'b0;
            r_vld5    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_en) r_vld1    <= i_in.valid;
            if (s2_en) r_vld2    <= r_vld1;
            if (s3_en) r_vld3    <= r_vld2;
            if (s4_en) r_vld4    <= r_vld3;
            if (s5_en) r_vld5    <= r_vld4;
            if (s6_en) r_out_vld <= r_vld5;
        end
    end

    // stage 1: 4x4 product array, a_j times a selected operand
    t_comp a_in  [4];
    t_comp b_in  [4];
    t_comp n_op1 [4];
    t_prod n_p1  [16];
    t_lin  n_lin1 [4];

    qau_pkg::t_cmd r_cmd1;
    t_prod         r_p1   [16];
    t_lin          r_lin1 [4];
    t_comp         r_v1   [3];

    always_comb begin
        a_in[0] = i_in.a_w;
        a_in[1] = i_in.a_x;
        a_in[2] = i_in.a_y;
        a_in[3] = i_in.a_z;
        b_in[0] = i_in.b_w;
        b_in[1] = i_in.b_x;
        b_in[2] = i_in.b_y;
        b_in[3] = i_in.b_z;
        case (i_in.command)
            qau_pkg::CMD_MUL: begin
                n_op1 = b_in;
            end
            qau_pkg::CMD_SCALE: begin
                for (int k = 0; k < 4; k++) n_op1[k] = i_in.scalar;
            end
            default: begin
                n_op1 = a_in;
            end
        endcase
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
                n_p1[4*j+k] = t_prod'(a_in[j]) * t_prod'(n_op1[k]);
            end
        end
        case (i_in.command)
            qau_pkg::CMD_ADD: begin
                for (int k = 0; k < 4; k++) n_lin1[k] = t_lin'(a_in[k]) + t_lin'(b_in[k]);
            end
            qau_pkg::CMD_SUB: begin
                for (int k = 0; k < 4; k++) n_lin1[k] = t_lin'(a_in[k]) - t_lin'(b_in[k]);
            end
            qau_pkg::CMD_CONJ: begin
                n_lin1[0] = t_lin'(a_in[0]);
                for (int k = 1; k < 4; k++) n_lin1[k] = -t_lin'(a_in[k]);
            end
            default: begin
                for (int k = 0; k < 4; k++) n_lin1[k] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_cmd1 <= i_in.command;
            r_p1   <= n_p1;
            r_lin1 <= n_lin1;
            r_v1[0] <= i_in.b_x;
            r_v1[1] <= i_in.b_y;
            r_v1[2] <= i_in.b_z;
        end
    end

    // stage 2: exact sums; rotation matrix terms row-major
    t_sum n_acc2 [4];
    t_sum n_m2   [9];

    qau_pkg::t_cmd r_cmd2;
    t_sum          r_acc2 [4];
    t_sum          r_m2   [9];
    t_comp         r_v2   [3];

    always_comb begin
        for (int k = 0; k < 4; k++) n_acc2[k] = '0;
        case (r_cmd1)
            qau_pkg::CMD_MUL: begin
                n_acc2[0] = ext(r_p1[0]) - ext(r_p1[5]) - ext(r_p1[10]) - ext(r_p1[15]);
                n_acc2[1] = ext(r_p1[1]) + ext(r_p1[4]) + ext(r_p1[11]) - ext(r_p1[14]);
                n_acc2[2] = ext(r_p1[2]) - ext(r_p1[7]) + ext(r_p1[8]) + ext(r_p1[13]);
                n_acc2[3] = ext(r_p1[3]) + ext(r_p1[6]) - ext(r_p1[9]) + ext(r_p1[12]);
            end
            qau_pkg::CMD_SCALE: begin
                for (int k = 0; k < 4; k++) n_acc2[k] = ext(r_p1[4*k]);
            end
            qau_pkg::CMD_NORM: begin
                n_acc2[0] = ext(r_p1[0]) + ext(r_p1[5]) + ext(r_p1[10]) + ext(r_p1[15]);
            end
            default: begin
                for (int k = 0; k < 4; k++) n_acc2[k] = t_sum'(r_lin1[k]);
            end
        endcase
        // squares at 0,5,10,15; ab 1, ac 2, ad 3, bc 6, bd 7, cd 11
        n_m2[0] = ext(r_p1[0]) + ext(r_p1[5]) - ext(r_p1[10]) - ext(r_p1[15]);
        n_m2[4] = ext(r_p1[0]) - ext(r_p1[5]) + ext(r_p1[10]) - ext(r_p1[15]);
        n_m2[8] = ext(r_p1[0]) - ext(r_p1[5]) - ext(r_p1[10]) + ext(r_p1[15]);
        n_m2[1] = (ext(r_p1[6])  - ext(r_p1[3])) <<< 1;
        n_m2[2] = (ext(r_p1[7])  + ext(r_p1[2])) <<< 1;
        n_m2[3] = (ext(r_p1[6])  + ext(r_p1[3])) <<< 1;
        n_m2[5] = (ext(r_p1[11]) - ext(r_p1[1])) <<< 1;
        n_m2[6] = (ext(r_p1[7])  - ext(r_p1[2])) <<< 1;
        n_m2[7] = (ext(r_p1[11]) + ext(r_p1[1])) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_cmd2 <= r_cmd1;
            r_acc2 <= n_acc2;
            r_m2   <= n_m2;
            r_v2   <= r_v1;
        end
    end

    // stage 3: rounding; matrix terms saturated
    t_sum  n_q3 [4];
    t_comp n_m3 [9];
    logic  n_mflag3;

    qau_pkg::t_cmd r_cmd3;
    t_sum          r_q3 [4];
    t_comp         r_m3 [9];
    logic          r_mflag3;
    t_comp         r_v3 [3];

    always_comb begin
        t_sum rm;
        logic clip;
        clip = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (r_cmd2 == qau_pkg::CMD_MUL || r_cmd2 == qau_pkg::CMD_SCALE ||
                r_cmd2 == qau_pkg::CMD_NORM) begin
                n_q3[k] = rnd(r_acc2[k]);
            end else begin
                n_q3[k] = r_acc2[k];
            end
        end
        for (int i = 0; i < 9; i++) begin
            rm      = rnd(r_m2[i]);
            n_m3[i] = sat(rm);
            clip    = clip | is_clip(rm);
        end
        n_mflag3 = clip && (r_cmd2 == qau_pkg::CMD_ROT || r_cmd2 == qau_pkg::CMD_ROT_CONJ);
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_cmd3   <= r_cmd2;
            r_q3     <= n_q3;
            r_m3     <= n_m3;
            r_mflag3 <= n_mflag3;
            r_v3     <= r_v2;
        end
    end

    // stage 4: matrix times vector, transposed for the conjugate rotation
    t_prod n_t4 [9];

    qau_pkg::t_cmd r_cmd4;
    t_sum          r_q4 [4];
    t_prod         r_t4 [9];
    logic          r_mflag4;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r_cmd3 == qau_pkg::CMD_ROT) begin
                    n_t4[3*r+c] = t_prod'(r_m3[3*r+c]) * t_prod'(r_v3[c]);
                end else begin
                    n_t4[3*r+c] = t_prod'(r_m3[3*c+r]) * t_prod'(r_v3[c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_cmd4   <= r_cmd3;
            r_q4     <= r_q3;
            r_t4     <= n_t4;
            r_mflag4 <= r_mflag3;
        end
    end

    // stage 5: rotated vector sums and rounding
    t_sum n_q5 [4];

    t_sum r_q5 [4];
    logic r_mflag5;

    always_comb begin
        if (r_cmd4 == qau_pkg::CMD_ROT || r_cmd4 == qau_pkg::CMD_ROT_CONJ) begin
            n_q5[0] = '0;
            for (int r = 0; r < 3; r++) begin
                n_q5[r+1] = rnd(ext(r_t4[3*r]) + ext(r_t4[3*r+1]) + ext(r_t4[3*r+2]));
            end
        end else begin
            n_q5 = r_q4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s5_en) begin
            r_q5     <= n_q5;
            r_mflag5 <= r_mflag4;
        end
    end

    // stage 6: output saturation
    t_comp n_res [4];
    logic  n_sat;

    t_comp r_res [4];
    logic  r_sat;

    always_comb begin
        n_sat = r_mflag5;
        for (int k = 0; k < 4; k++) begin
            n_res[k] = sat(r_q5[k]);
            n_sat    = n_sat | is_clip(r_q5[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s6_en) begin
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.r_w       = r_res[0];
    assign o_out.r_x       = r_res[1];
    assign o_out.r_y       = r_res[2];
    assign o_out.r_z       = r_res[3];
    assign o_out.saturated = r_sat;

    `QAU_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_out.valid)
    `QAU_ASSERT(a_accept_s1, i_clk, i_rst_n, i_in.valid && i_in.ready |=> r_vld1)
    `QAU_ASSERT(a_drain_ready, i_clk, i_rst_n, !o_out.valid |-> i_in.ready)
    `QAU_ASSERT(a_norm_pos, i_clk, i_rst_n, r_vld4 && r_cmd4 == qau_pkg::CMD_NORM |-> !r_q4[0][SW-1])
    `QAU_ASSERT(a_mflag_rot, i_clk, i_rst_n, r_vld4 && r_mflag4 |-> r_cmd4 == qau_pkg::CMD_ROT || r_cmd4 == qau_pkg::CMD_ROT_CONJ)

endmodule

// ===== verif/tb_top.sv =====
module tb_top;

    localparam int CW    = 16;
    localparam int FB    = 12;
    localparam int LIMIT = 200000;
    localparam int ONE_I = 1 << FB;

    localparam longint CMAX     = (longint'(1) << (CW - 1)) - 1;
    localparam longint CMIN     = -(longint'(1) << (CW - 1));
    localparam longint HALF_LSB = longint'(1) << (FB - 1);

    typedef logic signed [CW-1:0] t_comp;

    localparam t_comp MAXC = t_comp'(CMAX);
    localparam t_comp MINC = t_comp'(CMIN);
    localparam t_comp ONE  = t_comp'(ONE_I);
    localparam t_comp HALF = t_comp'(ONE_I / 2);

    typedef struct packed {
        qau_pkg::t_cmd cmd;
        t_comp         a_w;
        t_comp         a_x;
        t_comp         a_y;
        t_comp         a_z;
        t_comp         b_w;
        t_comp         b_x;
        t_comp         b_y;
        t_comp         b_z;
        t_comp         scl;
    } t_quat_op;

    typedef struct packed {
        t_comp r_w;
        t_comp r_x;
        t_comp r_y;
        t_comp r_z;
        logic  sat_flag;
    } t_quat_res;

    typedef struct packed {
        t_quat_op  op;
        logic      known;
        t_quat_res res;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qau_in_if  #(.COMPONENT_WIDTH(CW)) in_if ();
    qau_out_if #(.COMPONENT_WIDTH(CW)) out_if ();

    quaternion_arithmetic_unit #(
        .COMPONENT_WIDTH(CW),
        .FRACTION_BITS  (FB)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #4 i_clk = ~i_clk;

    t_quat_res pending_results [$];
    t_quat_res want_res;
    int        mismatch_count = 0;
    int        result_count   = 0;
    int        cycle_count    = 0;
    int        burst_left     = 0;
    int        stall_mode     = 0;
    int        stall_left     = 0;
    int        stall_phase    = 0;

    // fixed columns: cmd, A (w x y z), B (w x y z), scalar | typed result or none
    t_directed_row directed_ops [$] = '{
        '{'{qau_pkg::CMD_ADD, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 0},
          1'b1, '{MAXC, MAXC, MAXC, MAXC, 1'b1}},
        '{'{qau_pkg::CMD_ADD, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 0},
          1'b1, '{MINC, MINC, MINC, MINC, 1'b1}},
        '{'{qau_pkg::CMD_SUB, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, 0},
          1'b1, '{MINC, MINC, MINC, MINC, 1'b1}},
        '{'{qau_pkg::CMD_SUB, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, 0},
          1'b1, '{MAXC, MAXC, MAXC, MAXC, 1'b1}},
        '{'{qau_pkg::CMD_ADD, 1, 2, 3, 4, -1, -2, -3, -4, MAXC},
          1'b1, '{0, 0, 0, 0, 1'b0}},
        '{'{qau_pkg::CMD_CONJ, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC},
          1'b1, '{MINC, MAXC, MAXC, MAXC, 1'b1}},
        '{'{qau_pkg::CMD_CONJ, ONE, -1, 0, MAXC, 0, 0, 0, 0, 0},
          1'b1, '{ONE, 1, 0, -MAXC, 1'b0}},
        '{'{qau_pkg::CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0},
          1'b1, '{0, 0, 0, 0, 1'b0}},
        '{'{qau_pkg::CMD_NORM, ONE, 0, 0, 0, 0, 0, 0, 0, 0},
          1'b1, '{ONE, 0, 0, 0, 1'b0}},
        '{'{qau_pkg::CMD_NORM, MINC, MINC, MINC, MINC, 0, 0, 0, 0, 0},
          1'b1, '{MAXC, 0, 0, 0, 1'b1}},
        '{'{qau_pkg::CMD_NORM, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC},
          1'b1, '{MAXC, 0, 0, 0, 1'b1}},
        '{'{qau_pkg::CMD_MUL, ONE, 0, 0, 0, 1, 2, 3, 4, 0},
          1'b1, '{1, 2, 3, 4, 1'b0}},
        '{'{qau_pkg::CMD_MUL, 0, 0, 0, 0, MAXC, MAXC, MAXC, MAXC, 0},
          1'b1, '{0, 0, 0, 0, 1'b0}},
        '{'{qau_pkg::CMD_MUL, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, 0},
          1'b0, '0},
        '{'{qau_pkg::CMD_MUL, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 0},
          1'b0, '0},
        '{'{qau_pkg::CMD_MUL, 1000, -2000, 3000, -4000, -500, 600, -700, 800, 0},
          1'b0, '0},
        '{'{qau_pkg::CMD_SCALE, 1, 2, 3, 4, MAXC, MINC, MAXC, MINC, ONE},
          1'b1, '{1, 2, 3, 4, 1'b0}},
        '{'{qau_pkg::CMD_SCALE, MINC, MINC, MINC, MINC, 0, 0, 0, 0, MINC},
          1'b1, '{MAXC, MAXC, MAXC, MAXC, 1'b1}},
        '{'{qau_pkg::CMD_SCALE, 1, -1, 3, -3, 0, 0, 0, 0, HALF}, 1'b0, '0},
        '{'{qau_pkg::CMD_ROT, ONE, 0, 0, 0, 12345, 100, -200, 300, MINC},
          1'b1, '{0, 100, -200, 300, 1'b0}},
        '{'{qau_pkg::CMD_ROT_CONJ, ONE, 0, 0, 0, -12345, 100, -200, 300, MAXC},
          1'b1, '{0, 100, -200, 300, 1'b0}},
        '{'{qau_pkg::CMD_ROT, 2896, 0, 0, 2896, 0, ONE, 0, 0, 0}, 1'b0, '0},
        '{'{qau_pkg::CMD_ROT_CONJ, 2896, 0, 0, 2896, 0, ONE, 0, 0, 0}, 1'b0, '0},
        '{'{qau_pkg::CMD_ROT, MINC, MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, 0},
          1'b0, '0},
        '{'{qau_pkg::CMD_ROT_CONJ, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MINC, MINC},
          1'b0, '0}
    };

    function automatic longint round_q(input longint acc);
        return (acc + HALF_LSB) >>> FB;
    endfunction

    function automatic longint clip(input longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic t_quat_res quat_compute(input t_quat_op op);
        longint    a0, a1, a2, a3, b0, b1, b2, b3, sf, acc;
        longint    r [4];
        longint    m [3][3];
        longint    v [3];
        logic      clipped;
        t_quat_res res;
        a0 = op.a_w; a1 = op.a_x; a2 = op.a_y; a3 = op.a_z;
        b0 = op.b_w; b1 = op.b_x; b2 = op.b_y; b3 = op.b_z;
        sf = op.scl;
        v[0] = b1; v[1] = b2; v[2] = b3;
        for (int i = 0; i < 4; i++) r[i] = 0;
        clipped = 1'b0;
        case (op.cmd)
            qau_pkg::CMD_ADD: begin
                r[0] = a0 + b0; r[1] = a1 + b1; r[2] = a2 + b2; r[3] = a3 + b3;
            end
            qau_pkg::CMD_SUB: begin
                r[0] = a0 - b0; r[1] = a1 - b1; r[2] = a2 - b2; r[3] = a3 - b3;
            end
            qau_pkg::CMD_MUL: begin
                r[0] = round_q(a0 * b0 - a1 * b1 - a2 * b2 - a3 * b3);
                r[1] = round_q(a0 * b1 + a1 * b0 + a2 * b3 - a3 * b2);
                r[2] = round_q(a0 * b2 - a1 * b3 + a2 * b0 + a3 * b1);
                r[3] = round_q(a0 * b3 + a1 * b2 - a2 * b1 + a3 * b0);
            end
            qau_pkg::CMD_SCALE: begin
                r[0] = round_q(a0 * sf); r[1] = round_q(a1 * sf);
                r[2] = round_q(a2 * sf); r[3] = round_q(a3 * sf);
            end
            qau_pkg::CMD_CONJ: begin
                r[0] = a0; r[1] = -a1; r[2] = -a2; r[3] = -a3;
            end
            qau_pkg::CMD_ROT, qau_pkg::CMD_ROT_CONJ: begin
                m[0][0] = round_q(a0 * a0 + a1 * a1 - a2 * a2 - a3 * a3);
                m[1][1] = round_q(a0 * a0 - a1 * a1 + a2 * a2 - a3 * a3);
                m[2][2] = round_q(a0 * a0 - a1 * a1 - a2 * a2 + a3 * a3);
                m[0][1] = round_q(2 * (a1 * a2 - a0 * a3));
                m[0][2] = round_q(2 * (a1 * a3 + a0 * a2));
                m[1][0] = round_q(2 * (a1 * a2 + a0 * a3));
                m[1][2] = round_q(2 * (a2 * a3 - a0 * a1));
                m[2][0] = round_q(2 * (a1 * a3 - a0 * a2));
                m[2][1] = round_q(2 * (a2 * a3 + a0 * a1));
                for (int row = 0; row < 3; row++) begin
                    for (int col = 0; col < 3; col++) begin
                        if (clip(m[row][col]) != m[row][col]) clipped = 1'b1;
                        m[row][col] = clip(m[row][col]);
                    end
                end
                for (int row = 0; row < 3; row++) begin
                    acc = 0;
                    for (int col = 0; col < 3; col++) begin
                        acc += (op.cmd == qau_pkg::CMD_ROT ? m[row][col] : m[col][row])
                               * v[col];
                    end
                    r[row + 1] = round_q(acc);
                end
            end
            default: begin
                r[0] = round_q(a0 * a0 + a1 * a1 + a2 * a2 + a3 * a3);
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            if (clip(r[i]) != r[i]) clipped = 1'b1;
        end
        res.r_w      = t_comp'(clip(r[0]));
        res.r_x      = t_comp'(clip(r[1]));
        res.r_y      = t_comp'(clip(r[2]));
        res.r_z      = t_comp'(clip(r[3]));
        res.sat_flag = clipped;
        return res;
    endfunction

    // extremes, values in [-1.0, 1.0] and full range
    function automatic t_comp rand_comp();
        case ($urandom_range(0, 9))
            0:       return MINC;
            1:       return MAXC;
            2, 3, 4: return t_comp'(int'($urandom_range(0, 2 * ONE_I)) - ONE_I);
            default: return t_comp'($urandom);
        endcase
    endfunction

    function automatic t_quat_op random_op();
        t_quat_op op;
        op.cmd = qau_pkg::t_cmd'($urandom_range(0, 7));
        op.a_w = rand_comp();
        op.a_x = rand_comp();
        op.a_y = rand_comp();
        op.a_z = rand_comp();
        op.b_w = rand_comp();
        op.b_x = rand_comp();
        op.b_y = rand_comp();
        op.b_z = rand_comp();
        op.scl = rand_comp();
        return op;
    endfunction

    task automatic report_fail(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input t_comp got, input t_comp want);
        if (got !== want) begin
            report_fail($sformatf("result %0d %s got %0d want %0d",
                                  result_count, name, got, want));
        end
    endtask

    task automatic drive_item(input t_quat_op op, input t_quat_res want);
        in_if.valid   <= 1'b1;
        in_if.command <= op.cmd;
        in_if.a_w     <= op.a_w;
        in_if.a_x     <= op.a_x;
        in_if.a_y     <= op.a_y;
        in_if.a_z     <= op.a_z;
        in_if.b_w     <= op.b_w;
        in_if.b_x     <= op.b_x;
        in_if.b_y     <= op.b_y;
        in_if.b_z     <= op.b_z;
        in_if.scalar  <= op.scl;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(want);
    endtask

    // bursts of random length; a drain holds off until the pipe is empty
    task automatic pace(input bit drain);
        int gap;
        gap = 0;
        if (drain) begin
            gap = 1;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            while (drain && pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= (stall_phase % 5 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_fail($sformatf("result %0d with no item outstanding", result_count));
            end else begin
                want_res = pending_results.pop_front();
                check_field("r_w", out_if.r_w, want_res.r_w);
                check_field("r_x", out_if.r_x, want_res.r_x);
                check_field("r_y", out_if.r_y, want_res.r_y);
                check_field("r_z", out_if.r_z, want_res.r_z);
                check_field("saturated", t_comp'(out_if.saturated),
                            t_comp'(want_res.sat_flag));
            end
            result_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_quat_op op;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.command <= qau_pkg::CMD_ADD;
        in_if.a_w     <= '0;
        in_if.a_x     <= '0;
        in_if.a_y     <= '0;
        in_if.a_z     <= '0;
        in_if.b_w     <= '0;
        in_if.b_x     <= '0;
        in_if.b_y     <= '0;
        in_if.b_z     <= '0;
        in_if.scalar  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[k]) begin
            drive_item(directed_ops[k].op, directed_ops[k].known ? directed_ops[k].res
                                                                 : quat_compute(directed_ops[k].op));
            pace(k == directed_ops.size() - 1);
        end

        for (int n = 0; n < 550; n++) begin
            op = random_op();
            drive_item(op, quat_compute(op));
            pace(n == 274);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/qau_pkg.sv
src/qau_in_if.sv
src/qau_out_if.sv
src/quaternion_arithmetic_unit.sv
verif/tb_top.sv
